### rtl/ttd_pkg.sv
// Types and codes for the tagged tuple deserializer.
// No dependencies; imported by tagged_tuple_deserializer_top.
package ttd_pkg;

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_COUNT,
    PH_TYPES,
    PH_NUM,
    PH_SLEN,
    PH_SBYTES
  } phase_t;

  typedef logic [2:0] kind_t;
  typedef logic [1:0] ftype_t;

  localparam kind_t K_HEADER  = 3'd0;
  localparam kind_t K_INT32   = 3'd1;
  localparam kind_t K_INT64   = 3'd2;
  localparam kind_t K_FLOAT   = 3'd3;
  localparam kind_t K_STRLEN  = 3'd4;
  localparam kind_t K_STRBYTE = 3'd5;
  localparam kind_t K_BADTYPE = 3'd6;
  localparam kind_t K_TOOMANY = 3'd7;

  localparam ftype_t T_INT32  = 2'b00;
  localparam ftype_t T_INT64  = 2'b01;
  localparam ftype_t T_FLOAT  = 2'b10;
  localparam ftype_t T_STRING = 2'b11;

  localparam logic [7:0] FLAG_SET = 8'd1;

endpackage

### rtl/tagged_tuple_deserializer_top.sv
// Tagged tuple deserializer: parses a byte stream of serialized tuples into results.
// Depends on ttd_pkg; holds the field type table in a memory with a registered read.
//
//   port group   dir   payload                                           handshake
//   in_          in    data_byte[7:0]                                    valid / stall
//   out_         out   kind[2:0] value[63:0] waiting_flag field_number   valid / stall
//                      [7:0] last
//
// One byte per cycle unless stalled; each byte yields at most one registered item.
// Field types are fetched one field ahead from the type memory; every field spans
// at least two bytes, which covers the memory's read latency.
// Synchronous active-low reset returns the parser to the tuple flag byte.
// in_stall is raised only while a held item is stalled at the output.
module tagged_tuple_deserializer_top #(
  parameter int MAX_FIELDS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ttd_pkg::kind_t        out_kind,
  output logic [63:0]           out_value,
  output logic                  out_waiting_flag,
  output logic [7:0]            out_field_number,
  output logic                  out_last
);
  import ttd_pkg::*;

  localparam int AW    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int CW    = $clog2(MAX_FIELDS + 1);
  localparam int DEPTH = 1 << AW;

  phase_t          phase_r, phase_nxt;
  logic [2:0]      byte_pos_r, byte_pos_nxt;
  logic [31:0]     total_r, total_nxt;
  logic [CW-1:0]   cursor_r, cursor_nxt;
  logic [63:0]     vshift_r, vshift_nxt;
  logic [15:0]     str_rem_r, str_rem_nxt;
  logic            flag_r, flag_nxt;
  ftype_t          first_type_r, first_type_nxt;
  ftype_t          cur_type_r, cur_type_nxt;
  ftype_t          rd_type_r;

  ftype_t          type_mem [DEPTH];
  logic            type_we;
  logic [CW-1:0]   cursor_inc;
  logic [AW-1:0]   rd_addr;

  logic            out_valid_r;
  kind_t           out_kind_r;
  logic [63:0]     out_value_r;
  logic            out_flag_r;
  logic [7:0]      out_field_r;
  logic            out_last_r;

  logic            emit;
  kind_t           res_kind;
  logic [63:0]     res_value;
  logic            res_flag;
  logic [7:0]      res_field;
  logic            res_last;

  logic            acc;
  logic [31:0]     count_full;
  logic            too_many;
  logic            on_last;
  logic [15:0]     slen;
  logic [2:0]      byte_hi;
  logic            bad_type;
  ftype_t          start_type;
  phase_t          adv_phase;

  assign in_stall   = out_valid_r && out_stall;
  assign acc        = in_valid && !in_stall;
  assign count_full = {in_data_byte, total_r[23:0]};
  assign too_many   = count_full > 32'(MAX_FIELDS);
  assign on_last    = (32'(cursor_r) + 32'd1) == total_r;
  assign slen       = {in_data_byte, vshift_r[7:0]};
  assign byte_hi    = (cur_type_r == T_INT64) ? 3'd7 : 3'd3;
  assign bad_type   = in_data_byte > 8'(T_STRING);
  assign start_type = (cursor_r == '0) ? in_data_byte[1:0] : first_type_r;
  assign adv_phase  = on_last ? PH_FLAG : ((rd_type_r == T_STRING) ? PH_SLEN : PH_NUM);
  assign cursor_inc = cursor_r + 1'b1;
  assign rd_addr    = cursor_inc[AW-1:0];
  assign type_we    = acc && (phase_r == PH_TYPES) && !bad_type;

  always_ff @(posedge clk) begin
    if (type_we) begin
      type_mem[cursor_r[AW-1:0]] <= in_data_byte[1:0];
    end
    rd_type_r <= type_mem[rd_addr];
  end

  always_comb begin
    phase_nxt      = phase_r;
    byte_pos_nxt   = byte_pos_r;
    total_nxt      = total_r;
    cursor_nxt     = cursor_r;
    vshift_nxt     = vshift_r;
    str_rem_nxt    = str_rem_r;
    flag_nxt       = flag_r;
    first_type_nxt = first_type_r;
    cur_type_nxt   = cur_type_r;
    case (phase_r)
      PH_FLAG: begin
        flag_nxt     = (in_data_byte == FLAG_SET);
        total_nxt    = '0;
        byte_pos_nxt = '0;
        phase_nxt    = PH_COUNT;
      end
      PH_COUNT: begin
        total_nxt[{byte_pos_r[1:0], 3'b000} +: 8] = in_data_byte;
        byte_pos_nxt = byte_pos_r + 3'd1;
        if (byte_pos_r == 3'd3) begin
          byte_pos_nxt = '0;
          cursor_nxt   = '0;
          phase_nxt    = (too_many || count_full == '0) ? PH_FLAG : PH_TYPES;
        end
      end
      PH_TYPES: begin
        if (bad_type) begin
          phase_nxt = PH_FLAG;
        end else begin
          if (cursor_r == '0) begin
            first_type_nxt = in_data_byte[1:0];
          end
          if (on_last) begin
            cursor_nxt   = '0;
            byte_pos_nxt = '0;
            cur_type_nxt = start_type;
            phase_nxt    = (start_type == T_STRING) ? PH_SLEN : PH_NUM;
          end else begin
            cursor_nxt = cursor_inc;
          end
        end
      end
      PH_NUM: begin
        vshift_nxt[{byte_pos_r, 3'b000} +: 8] = in_data_byte;
        byte_pos_nxt = byte_pos_r + 3'd1;
        if (byte_pos_r == byte_hi) begin
          byte_pos_nxt = '0;
          cursor_nxt   = cursor_inc;
          cur_type_nxt = rd_type_r;
          phase_nxt    = adv_phase;
        end
      end
      PH_SLEN: begin
        if (byte_pos_r == 3'd0) begin
          vshift_nxt[7:0] = in_data_byte;
          byte_pos_nxt    = 3'd1;
        end else begin
          byte_pos_nxt = '0;
          if (slen == '0) begin
            cursor_nxt   = cursor_inc;
            cur_type_nxt = rd_type_r;
            phase_nxt    = adv_phase;
          end else begin
            str_rem_nxt = slen;
            phase_nxt   = PH_SBYTES;
          end
        end
      end
      PH_SBYTES: begin
        str_rem_nxt = str_rem_r - 16'd1;
        if (str_rem_r == 16'd1) begin
          byte_pos_nxt = '0;
          cursor_nxt   = cursor_inc;
          cur_type_nxt = rd_type_r;
          phase_nxt    = adv_phase;
        end
      end
      default: begin
        phase_nxt = PH_FLAG;
      end
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    res_kind  = K_HEADER;
    res_value = '0;
    res_flag  = 1'b0;
    res_field = 8'(cursor_r);
    res_last  = 1'b0;
    case (phase_r)
      PH_COUNT: begin
        if (byte_pos_r == 3'd3) begin
          emit      = 1'b1;
          res_field = '0;
          res_value = {32'd0, count_full};
          if (too_many) begin
            res_kind = K_TOOMANY;
            res_last = 1'b1;
          end else begin
            res_kind = K_HEADER;
            res_flag = flag_r;
            res_last = (count_full == '0);
          end
        end
      end
      PH_TYPES: begin
        if (bad_type) begin
          emit      = 1'b1;
          res_kind  = K_BADTYPE;
          res_value = {56'd0, in_data_byte};
          res_last  = 1'b1;
        end
      end
      PH_NUM: begin
        if (byte_pos_r == byte_hi) begin
          emit     = 1'b1;
          res_last = on_last;
          case (cur_type_r)
            T_INT64: res_kind = K_INT64;
            T_FLOAT: res_kind = K_FLOAT;
            default: res_kind = K_INT32;
          endcase
          if (cur_type_r == T_INT64) begin
            res_value = {in_data_byte, vshift_r[55:0]};
          end else begin
            res_value = {32'd0, in_data_byte, vshift_r[23:0]};
          end
        end
      end
      PH_SLEN: begin
        if (byte_pos_r != 3'd0) begin
          emit      = 1'b1;
          res_kind  = K_STRLEN;
          res_value = {48'd0, slen};
          res_last  = (slen == '0) && on_last;
        end
      end
      PH_SBYTES: begin
        emit      = 1'b1;
        res_kind  = K_STRBYTE;
        res_value = {56'd0, in_data_byte};
        res_last  = (str_rem_r == 16'd1) && on_last;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FLAG;
      byte_pos_r   <= '0;
      total_r      <= '0;
      cursor_r     <= '0;
      vshift_r     <= '0;
      str_rem_r    <= '0;
      flag_r       <= 1'b0;
      first_type_r <= T_INT32;
      cur_type_r   <= T_INT32;
      out_valid_r  <= 1'b0;
    end else begin
      if (acc) begin
        phase_r      <= phase_nxt;
        byte_pos_r   <= byte_pos_nxt;
        total_r      <= total_nxt;
        cursor_r     <= cursor_nxt;
        vshift_r     <= vshift_nxt;
        str_rem_r    <= str_rem_nxt;
        flag_r       <= flag_nxt;
        first_type_r <= first_type_nxt;
        cur_type_r   <= cur_type_nxt;
      end
      if (acc && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      out_kind_r  <= res_kind;
      out_value_r <= res_value;
      out_flag_r  <= res_flag;
      out_field_r <= res_field;
      out_last_r  <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_value        = out_value_r;
  assign out_waiting_flag = out_flag_r;
  assign out_field_number = out_field_r;
  assign out_last         = out_last_r;

  a_data_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_NUM || phase_r == PH_SLEN || phase_r == PH_SBYTES)
      |-> (32'(cursor_r) < total_r))
    else $error("field cursor beyond field count in data phase");

  a_str_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SBYTES) |-> (str_rem_r != '0))
    else $error("string byte phase with nothing remaining");

  a_flag_only_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != K_HEADER) |-> !out_waiting_flag)
    else $error("flag set on a non-header item");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == K_TOOMANY || out_kind == K_BADTYPE)) |-> out_last)
    else $error("error item not marked last");

  a_end_of_tuple: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && emit && res_last) |=> (phase_r == PH_FLAG))
    else $error("parser did not return to flag byte after last item");

endmodule
